// ----- src/nsr_pkg.sv -----
// shared types and constants of the nmea sentence receiver
`timescale 1ns / 1ps
package nsr_pkg;

  localparam int MAX_LEN    = 128;
  localparam int MAX_FIELDS = 16;
  localparam int LEN_W      = 8;
  localparam int FIELD_W    = $clog2(MAX_FIELDS + 1);
  localparam int NAME_LEN   = 5;
  localparam int POS_W      = $clog2(NAME_LEN);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [8*NAME_LEN-1:0] NAME_MWV = "IIMWV";
  localparam logic [8*NAME_LEN-1:0] NAME_XDR = "WIXDR";

  // position of the comma that closes a valid address
  localparam int ADDR_COMMA_IDX = NAME_LEN + 1;
  localparam int MIN_LEN        = 5;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FRAMING    = 2'd1,
    ST_CHECKSUM   = 2'd2,
    ST_NO_HANDLER = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TALKER_NONE = 2'd0,
    TALKER_MWV  = 2'd1,
    TALKER_XDR  = 2'd2
  } talker_t;

  // one classified word from the front
  typedef struct packed {
    logic [7:0]          data;
    logic                dollar;
    logic                term;
    logic                comma;
    logic                star;
    logic                hex_ok;
    logic [3:0]          hex;
    logic [NAME_LEN-1:0] mwv_hit;
    logic [NAME_LEN-1:0] xdr_hit;
  } item_t;

  // what the back keeps of the last three words
  typedef struct packed {
    logic       star;
    logic       hex_ok;
    logic [3:0] hex;
  } recent_t;

endpackage

// ----- src/nmea_sentence_receiver_core.sv -----
// top level of the nmea sentence receiver
//
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_rx_byte
// out      output     out_valid / out_stall status, talker, field_count, checksums, length
// cfg      input      cfg_we                cfg_wdata (handler mask)
//
// one word per cycle sustained while in_stall is low; an accepted word reaches the result
// register through front classify, queue write and back update, in that order
// the back takes a word from the four-entry queue whenever the result register is free
// reset is synchronous active low, no clearing pass; handler mask resets to both present
// out_stall holds the result and lets the queue fill; in_stall rises only when it is full
`timescale 1ns / 1ps
module nmea_sentence_receiver_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [1:0]                  out_talker,
  output logic [nsr_pkg::FIELD_W-1:0] out_field_count,
  output logic [7:0]                  out_calc_checksum,
  output logic [7:0]                  out_recv_checksum,
  output logic [nsr_pkg::LEN_W-1:0]   out_sentence_length
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  nsr_pkg::item_t push_item;
  nsr_pkg::item_t pop_item;

  nsr_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  nsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  nsr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .q_empty             (q_empty),
    .q_item              (pop_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_talker          (out_talker),
    .out_field_count     (out_field_count),
    .out_calc_checksum   (out_calc_checksum),
    .out_recv_checksum   (out_recv_checksum),
    .out_sentence_length (out_sentence_length)
  );

endmodule

// ----- src/nsr_front.sv -----
// front: accepts input words and classifies them into the queue
`timescale 1ns / 1ps
module nsr_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  input  logic          q_full,
  output logic          q_push,
  output nsr_pkg::item_t q_item
);

  always_comb begin
    q_item        = '0;
    q_item.data   = in_rx_byte;
    q_item.dollar = (in_rx_byte == nsr_pkg::CH_DOLLAR);
    q_item.term   = (in_rx_byte == nsr_pkg::CH_CR) || (in_rx_byte == nsr_pkg::CH_LF);
    q_item.comma  = (in_rx_byte == nsr_pkg::CH_COMMA);
    q_item.star   = (in_rx_byte == nsr_pkg::CH_STAR);
    if (in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39) begin
      q_item.hex_ok = 1'b1;
      q_item.hex    = in_rx_byte[3:0];
    end else if ((in_rx_byte >= 8'h41 && in_rx_byte <= 8'h46) ||
                 (in_rx_byte >= 8'h61 && in_rx_byte <= 8'h66)) begin
      q_item.hex_ok = 1'b1;
      q_item.hex    = in_rx_byte[3:0] + 4'd9;
    end
    for (int p = 0; p < nsr_pkg::NAME_LEN; p++) begin
      q_item.mwv_hit[p] =
        (in_rx_byte == nsr_pkg::NAME_MWV[8*(nsr_pkg::NAME_LEN-1-p) +: 8]);
      q_item.xdr_hit[p] =
        (in_rx_byte == nsr_pkg::NAME_XDR[8*(nsr_pkg::NAME_LEN-1-p) +: 8]);
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- src/nsr_queue.sv -----
// short queue of classified words between front and back
`timescale 1ns / 1ps
module nsr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nsr_pkg::item_t push_item,
  input  logic           pop,
  output nsr_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);

  nsr_pkg::item_t                 slot_r [nsr_pkg::Q_DEPTH];
  logic [nsr_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [nsr_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [nsr_pkg::Q_CNT_W-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item = slot_r[rd_ptr_r];
  assign full     = (count_r == nsr_pkg::Q_CNT_W'(nsr_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);

endmodule

// ----- src/nsr_back.sv -----
// back: sentence state, checksum and result register
`timescale 1ns / 1ps
module nsr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  input  logic                        q_empty,
  input  nsr_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [1:0]                  out_talker,
  output logic [nsr_pkg::FIELD_W-1:0] out_field_count,
  output logic [7:0]                  out_calc_checksum,
  output logic [7:0]                  out_recv_checksum,
  output logic [nsr_pkg::LEN_W-1:0]   out_sentence_length
);

  logic [1:0]                  mask_r;
  logic                        receiving_r, receiving_nxt;
  logic [nsr_pkg::LEN_W-1:0]   count_r, count_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic                        star_seen_r, star_seen_nxt;
  nsr_pkg::recent_t            recent_r [3];
  nsr_pkg::recent_t            recent_nxt [3];
  logic [1:0]                  alive_r, alive_nxt;
  logic                        closed_r, closed_nxt;
  logic [nsr_pkg::FIELD_W-1:0] fields_r, fields_nxt;
  logic                        nonempty_r, nonempty_nxt;

  logic                        out_valid_r, out_valid_nxt;
  nsr_pkg::status_t            status_r, status_nxt;
  nsr_pkg::talker_t            talker_r, talker_nxt;
  logic [nsr_pkg::FIELD_W-1:0] fcount_r, fcount_nxt;
  logic [7:0]                  calc_r, calc_nxt;
  logic [7:0]                  recv_r, recv_nxt;
  logic [nsr_pkg::LEN_W-1:0]   len_r, len_nxt;

  logic [nsr_pkg::LEN_W-1:0]   len_inc;
  logic [nsr_pkg::POS_W-1:0]   pos;
  logic [7:0]                  recv_val;

  assign q_pop   = !q_empty && (!out_valid_r || !out_stall);
  assign len_inc = count_r + 1'b1;
  assign pos     = nsr_pkg::POS_W'(count_r - 1'b1);

  always_comb begin
    recv_val = '0;
    if (recent_r[1].hex_ok) begin
      recv_val = recent_r[2].hex_ok ? {recent_r[1].hex, recent_r[2].hex}
                                    : {4'd0, recent_r[1].hex};
    end
  end

  always_comb begin
    receiving_nxt = receiving_r;
    count_nxt     = count_r;
    xor_nxt       = xor_r;
    star_seen_nxt = star_seen_r;
    recent_nxt    = recent_r;
    alive_nxt     = alive_r;
    closed_nxt    = closed_r;
    fields_nxt    = fields_r;
    nonempty_nxt  = nonempty_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    talker_nxt    = talker_r;
    fcount_nxt    = fcount_r;
    calc_nxt      = calc_r;
    recv_nxt      = recv_r;
    len_nxt       = len_r;

    if (q_pop) begin
      if (!receiving_r || count_r >= nsr_pkg::LEN_W'(nsr_pkg::MAX_LEN) || q_item.term) begin
        // start fresh for idle, overflow and end of sentence
        receiving_nxt = 1'b0;
        count_nxt     = '0;
        xor_nxt       = '0;
        star_seen_nxt = 1'b0;
        recent_nxt    = '{default: '0};
        alive_nxt     = 2'b11;
        closed_nxt    = 1'b0;
        fields_nxt    = '0;
        nonempty_nxt  = 1'b0;
        if (!receiving_r && q_item.dollar) begin
          receiving_nxt = 1'b1;
          count_nxt     = nsr_pkg::LEN_W'(1);
          nonempty_nxt  = 1'b1;
        end
      end else begin
        count_nxt = len_inc;
        if (!closed_r) begin
          if (q_item.comma) begin
            closed_nxt = 1'b1;
            if (count_r != nsr_pkg::LEN_W'(nsr_pkg::ADDR_COMMA_IDX)) begin
              alive_nxt = '0;
            end
          end else if (count_r >= nsr_pkg::LEN_W'(1) &&
                       count_r <= nsr_pkg::LEN_W'(nsr_pkg::NAME_LEN)) begin
            alive_nxt[0] = alive_r[0] && q_item.mwv_hit[pos];
            alive_nxt[1] = alive_r[1] && q_item.xdr_hit[pos];
          end else begin
            alive_nxt = '0;
          end
        end
        if (!star_seen_r) begin
          if (q_item.star) begin
            star_seen_nxt = 1'b1;
          end else begin
            xor_nxt = xor_r ^ q_item.data;
            if (q_item.comma) begin
              if (fields_r < nsr_pkg::FIELD_W'(nsr_pkg::MAX_FIELDS)) begin
                fields_nxt = fields_r + 1'b1;
              end
              nonempty_nxt = 1'b0;
            end else begin
              nonempty_nxt = 1'b1;
            end
          end
        end
        recent_nxt[0] = recent_r[1];
        recent_nxt[1] = recent_r[2];
        recent_nxt[2] = '{star: q_item.star, hex_ok: q_item.hex_ok, hex: q_item.hex};
      end

      if (receiving_r && count_r < nsr_pkg::LEN_W'(nsr_pkg::MAX_LEN) && q_item.term) begin
        out_valid_nxt = 1'b1;
        talker_nxt    = nsr_pkg::TALKER_NONE;
        if (closed_r && alive_r[0]) begin
          talker_nxt = nsr_pkg::TALKER_MWV;
        end else if (closed_r && alive_r[1]) begin
          talker_nxt = nsr_pkg::TALKER_XDR;
        end
        fcount_nxt = fields_r;
        if (nonempty_r && fields_r < nsr_pkg::FIELD_W'(nsr_pkg::MAX_FIELDS)) begin
          fcount_nxt = fields_r + 1'b1;
        end
        calc_nxt = xor_r;
        len_nxt  = len_inc;
        recv_nxt = '0;
        if (len_inc < nsr_pkg::LEN_W'(nsr_pkg::MIN_LEN) || !recent_r[0].star) begin
          status_nxt = nsr_pkg::ST_FRAMING;
        end else begin
          recv_nxt = recv_val;
          if (recv_val != xor_r) begin
            status_nxt = nsr_pkg::ST_CHECKSUM;
          end else if ((closed_r && alive_r[0] && mask_r[0]) ||
                       (closed_r && !alive_r[0] && alive_r[1] && mask_r[1])) begin
            status_nxt = nsr_pkg::ST_OK;
          end else begin
            status_nxt = nsr_pkg::ST_NO_HANDLER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= 2'b11;
      receiving_r <= 1'b0;
      count_r     <= '0;
      xor_r       <= '0;
      star_seen_r <= 1'b0;
      recent_r    <= '{default: '0};
      alive_r     <= 2'b11;
      closed_r    <= 1'b0;
      fields_r    <= '0;
      nonempty_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      receiving_r <= receiving_nxt;
      count_r     <= count_nxt;
      xor_r       <= xor_nxt;
      star_seen_r <= star_seen_nxt;
      recent_r    <= recent_nxt;
      alive_r     <= alive_nxt;
      closed_r    <= closed_nxt;
      fields_r    <= fields_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    talker_r <= talker_nxt;
    fcount_r <= fcount_nxt;
    calc_r   <= calc_nxt;
    recv_r   <= recv_nxt;
    len_r    <= len_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_talker          = talker_r;
  assign out_field_count     = fcount_r;
  assign out_calc_checksum   = calc_r;
  assign out_recv_checksum   = recv_r;
  assign out_sentence_length = len_r;

endmodule

// ----- tb/nmea_sentence_receiver_core_test.sv -----
// testbench of the nmea sentence receiver: directed and random byte streams against a predictor
`timescale 1ns / 1ps
module nmea_sentence_receiver_core_test;

  typedef struct {
    nsr_pkg::status_t            status;
    nsr_pkg::talker_t            talker;
    logic [nsr_pkg::FIELD_W-1:0] fields;
    logic [7:0]                  calc_sum;
    logic [7:0]                  recv_sum;
    logic [nsr_pkg::LEN_W-1:0]   length;
  } sentence_report_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [1:0]                  cfg_wdata = 2'd0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [7:0]                  in_rx_byte = 8'd0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  out_status;
  logic [1:0]                  out_talker;
  logic [nsr_pkg::FIELD_W-1:0] out_field_count;
  logic [7:0]                  out_calc_checksum;
  logic [7:0]                  out_recv_checksum;
  logic [nsr_pkg::LEN_W-1:0]   out_sentence_length;

  nmea_sentence_receiver_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_talker          (out_talker),
    .out_field_count     (out_field_count),
    .out_calc_checksum   (out_calc_checksum),
    .out_recv_checksum   (out_recv_checksum),
    .out_sentence_length (out_sentence_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sentence predictor state
  logic [1:0]                  mask_model;
  logic                        rx_active;
  int                          rx_len;
  logic [7:0]                  rx_xor;
  logic                        rx_star;
  logic [7:0]                  tail [3];
  logic [1:0]                  name_alive;
  logic                        addr_done;
  logic [nsr_pkg::FIELD_W-1:0] field_cnt;
  logic                        field_open;

  sentence_report_t   pending_reports[$];
  logic [7:0]         line_buf[$];
  int                 bytes_taken = 0;
  int                 reports_made = 0;
  int                 mismatches = 0;
  bit                 in_gaps = 1'b1;
  bit                 out_gaps = 1'b1;
  int                 stall_left = 0;
  int                 hold_left = 0;

  function automatic void clear_sentence();
    rx_active  = 1'b0;
    rx_len     = 0;
    rx_xor     = 8'd0;
    rx_star    = 1'b0;
    foreach (tail[i]) tail[i] = 8'd0;
    name_alive = 2'b11;
    addr_done  = 1'b0;
    field_cnt  = '0;
    field_open = 1'b0;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 10) return 8'("0" + nib);
    return 8'((lower ? "a" : "A") + nib - 10);
  endfunction

  function automatic void absorb_byte(input logic [7:0] c);
    int               pos;
    int               d1;
    int               d2;
    sentence_report_t r;
    if (!rx_active) begin
      if (c == nsr_pkg::CH_DOLLAR) begin
        clear_sentence();
        rx_active  = 1'b1;
        rx_len     = 1;
        field_open = 1'b1;
      end
      return;
    end
    if (rx_len >= nsr_pkg::MAX_LEN) begin
      clear_sentence();
      return;
    end
    pos = rx_len;
    rx_len++;
    if (c == nsr_pkg::CH_CR || c == nsr_pkg::CH_LF) begin
      r.talker = nsr_pkg::TALKER_NONE;
      if (addr_done) begin
        if (name_alive[0]) r.talker = nsr_pkg::TALKER_MWV;
        else if (name_alive[1]) r.talker = nsr_pkg::TALKER_XDR;
      end
      r.fields = field_cnt;
      if (field_open && field_cnt < nsr_pkg::MAX_FIELDS) r.fields = field_cnt + 1'b1;
      r.recv_sum = 8'd0;
      if (rx_len < nsr_pkg::MIN_LEN || tail[0] != nsr_pkg::CH_STAR) begin
        r.status = nsr_pkg::ST_FRAMING;
      end else begin
        d1 = hex_digit(tail[1]);
        d2 = hex_digit(tail[2]);
        if (d1 >= 0) r.recv_sum = (d2 >= 0) ? 8'(d1 * 16 + d2) : 8'(d1);
        if (r.recv_sum != rx_xor) r.status = nsr_pkg::ST_CHECKSUM;
        else if (r.talker == nsr_pkg::TALKER_MWV && mask_model[0]) r.status = nsr_pkg::ST_OK;
        else if (r.talker == nsr_pkg::TALKER_XDR && mask_model[1]) r.status = nsr_pkg::ST_OK;
        else r.status = nsr_pkg::ST_NO_HANDLER;
      end
      r.calc_sum = rx_xor;
      r.length   = nsr_pkg::LEN_W'(rx_len);
      pending_reports.push_back(r);
      reports_made++;
      clear_sentence();
      return;
    end
    if (!addr_done) begin
      if (c == nsr_pkg::CH_COMMA) begin
        addr_done = 1'b1;
        if (pos != nsr_pkg::ADDR_COMMA_IDX) name_alive = 2'b00;
      end else if (pos >= 1 && pos <= nsr_pkg::NAME_LEN) begin
        if (c != nsr_pkg::NAME_MWV[8*(nsr_pkg::NAME_LEN-pos) +: 8]) name_alive[0] = 1'b0;
        if (c != nsr_pkg::NAME_XDR[8*(nsr_pkg::NAME_LEN-pos) +: 8]) name_alive[1] = 1'b0;
      end else begin
        name_alive = 2'b00;
      end
    end
    if (!rx_star) begin
      if (c == nsr_pkg::CH_STAR) begin
        rx_star = 1'b1;
      end else begin
        rx_xor = rx_xor ^ c;
        if (c == nsr_pkg::CH_COMMA) begin
          if (field_cnt < nsr_pkg::MAX_FIELDS) field_cnt = field_cnt + 1'b1;
          field_open = 1'b0;
        end else begin
          field_open = 1'b1;
        end
      end
    end
    tail[0] = tail[1];
    tail[1] = tail[2];
    tail[2] = c;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    $display("tb: %s mismatch at %0t: got %0h want %0h", what, $time, got, want);
  endtask

  task automatic check_report();
    sentence_report_t want;
    if (pending_reports.size() == 0) begin
      flag_mismatch("unexpected report", 8'(out_status), 8'd0);
      return;
    end
    want = pending_reports.pop_front();
    if (out_status !== want.status)
      flag_mismatch("status", 8'(out_status), 8'(want.status));
    if (out_talker !== want.talker)
      flag_mismatch("talker", 8'(out_talker), 8'(want.talker));
    if (out_field_count !== want.fields)
      flag_mismatch("field count", 8'(out_field_count), 8'(want.fields));
    if (out_calc_checksum !== want.calc_sum)
      flag_mismatch("calc checksum", out_calc_checksum, want.calc_sum);
    if (out_recv_checksum !== want.recv_sum)
      flag_mismatch("recv checksum", out_recv_checksum, want.recv_sum);
    if (out_sentence_length !== want.length)
      flag_mismatch("length", out_sentence_length, want.length);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      check_report();
      stall_left = out_gaps ? $urandom_range(0, 5) : 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (hold_left > 0) || (stall_left > 0);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (rx_active || b == nsr_pkg::CH_DOLLAR) bytes_taken++;
    absorb_byte(b);
  endtask

  task automatic send_raw(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic load_text(input string s);
    line_buf.delete();
    push_text(s);
  endtask

  // frames line_buf as a sentence with checksum digits, flip corrupts them
  task automatic send_line(input logic [7:0] flip, input bit lower, input logic [7:0] term);
    logic [7:0] x;
    bit         starred;
    x = 8'd0;
    starred = 1'b0;
    foreach (line_buf[i]) begin
      if (line_buf[i] == nsr_pkg::CH_STAR) starred = 1'b1;
      if (!starred) x = x ^ line_buf[i];
    end
    x = x ^ flip;
    send_byte(nsr_pkg::CH_DOLLAR);
    foreach (line_buf[i]) send_byte(line_buf[i]);
    send_byte(nsr_pkg::CH_STAR);
    send_byte(hex_char(x[7:4], lower));
    send_byte(hex_char(x[3:0], lower));
    send_byte(term);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mask(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    mask_model = m;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] field_byte();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
    end while (c == nsr_pkg::CH_CR || c == nsr_pkg::CH_LF || c == nsr_pkg::CH_STAR ||
               c == nsr_pkg::CH_COMMA);
    return c;
  endfunction

  task automatic send_random_sentence();
    int nfields;
    int flen;
    int j;
    logic [7:0] flip;
    line_buf.delete();
    case ($urandom_range(0, 5))
      0, 1: push_text("IIMWV");
      2, 3: push_text("WIXDR");
      4: begin
        repeat (5) line_buf.push_back(8'($urandom_range("A", "Z")));
      end
      default: begin
        push_text($urandom_range(0, 1) ? "IIMWV" : "WIXDR");
        j = $urandom_range(0, 6);
        if (j < 5) line_buf[j] = 8'($urandom_range("A", "Z"));
        else if (j == 5) line_buf.push_back("V");
        else void'(line_buf.pop_back());
      end
    endcase
    if ($urandom_range(0, 11) != 0) begin
      nfields = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 8);
      for (int f = 0; f <= nfields; f++) begin
        line_buf.push_back(nsr_pkg::CH_COMMA);
        flen = $urandom_range(0, 4);
        repeat (flen) line_buf.push_back(field_byte());
      end
    end
    if ($urandom_range(0, 39) == 0) repeat (130) line_buf.push_back(field_byte());
    flip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    send_line(flip, 1'($urandom_range(0, 1)),
              $urandom_range(0, 1) ? nsr_pkg::CH_CR : nsr_pkg::CH_LF);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    if ($urandom_range(0, 1)) begin
      send_byte(nsr_pkg::CH_DOLLAR);
      repeat (n) send_byte(field_byte());
      send_byte($urandom_range(0, 1) ? nsr_pkg::CH_CR : nsr_pkg::CH_LF);
    end else begin
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_reset_defaults();
    load_text("IIMWV,270.0,R,5.2,N,A");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
    load_text("WIXDR,C,21.5,C,T1");
    send_line(8'd0, 1'b1, nsr_pkg::CH_LF);
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(nsr_pkg::CH_CR);
    send_byte(nsr_pkg::CH_LF);
    send_byte(nsr_pkg::CH_STAR);
    send_byte(nsr_pkg::CH_COMMA);
    load_text("IIMWV,1");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
  endtask

  task automatic test_framing();
    send_byte(nsr_pkg::CH_DOLLAR);
    send_byte(nsr_pkg::CH_CR);
    send_raw("$A*1");
    send_byte(nsr_pkg::CH_LF);
    send_raw("$IIMWV,1*5");
    send_byte(nsr_pkg::CH_CR);
    send_raw("$*00");
    send_byte(nsr_pkg::CH_CR);
    send_raw("$WIXDR,C");
    send_byte(nsr_pkg::CH_LF);
  endtask

  task automatic test_checksum_digits();
    send_raw("$AB*zz");
    send_byte(nsr_pkg::CH_CR);
    send_raw("$AB*3z");
    send_byte(nsr_pkg::CH_CR);
    load_text("IIMWV,2");
    send_line(8'h5A, 1'b0, nsr_pkg::CH_CR);
  endtask

  task automatic test_address_rules();
    load_text("GPGGA,1");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
    load_text("IIMWV");
    send_line(8'd0, 1'b0, nsr_pkg::CH_LF);
    load_text("IIMWVX,1");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
    load_text("II*WV,1");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
    load_text("WIXDR,A$B");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    send_line(8'd0, 1'b1, nsr_pkg::CH_CR);
  endtask

  task automatic test_field_count();
    load_text("IIMWV,1,");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
    load_text("WIXDR");
    repeat (20) push_text(",x");
    send_line(8'd0, 1'b0, nsr_pkg::CH_LF);
  endtask

  task automatic test_length_limits();
    load_text("IIMWV,");
    repeat (117) line_buf.push_back("7");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
    send_byte(nsr_pkg::CH_DOLLAR);
    repeat (127) send_byte("A");
    send_byte(nsr_pkg::CH_CR);
    load_text("WIXDR,P,1");
    send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
  endtask

  task automatic test_handler_mask();
    for (int m = 0; m < 4; m++) begin
      settle();
      write_mask(m[1:0]);
      load_text("IIMWV,9");
      send_line(8'd0, 1'b0, nsr_pkg::CH_CR);
      load_text("WIXDR,9");
      send_line(8'd0, 1'b0, nsr_pkg::CH_LF);
    end
  endtask

  task automatic test_backpressure();
    settle();
    in_gaps = 1'b0;
    hold_left <= 200;
    repeat (8) send_random_sentence();
    in_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int bytes_goal;
    int reports_goal;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      write_mask(2'($urandom_range(0, 3)));
      in_gaps = (phase != 1);
      out_gaps = (phase != 2);
      bytes_goal = bytes_taken + 150;
      reports_goal = reports_made + 6;
      while (bytes_taken < bytes_goal || reports_made < reports_goal) begin
        if ($urandom_range(0, 4) != 0) send_random_sentence();
        else send_noise();
      end
    end
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  initial begin
    mask_model = 2'd3;
    clear_sentence();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_idle_bytes();
    test_framing();
    test_checksum_digits();
    test_address_rules();
    test_field_count();
    test_length_limits();
    test_handler_mask();
    test_backpressure();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
